// ===== rtl/core/aesenc_pkg.sv =====
`default_nettype none

package aesenc_pkg;

  localparam int unsigned BLOCK_W = 128;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned ROW_W   = 4;   // round-key rows 0..14
  localparam int unsigned WIDX_W  = 6;   // schedule words 0..59
  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_3    = 3'd4;

  // key length codes
  localparam logic [1:0] MODE_128 = 2'd0;
  localparam logic [1:0] MODE_192 = 2'd1;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] GF_POLY    = 8'h1b;

  typedef struct packed {
    logic busy;
    logic done;
  } exp_status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // index of the last key word: nk - 1
  function automatic logic [2:0] nk_last(input logic [1:0] mode);
    unique case (mode)
      MODE_128: nk_last = 3'd3;
      MODE_192: nk_last = 3'd5;
      default:  nk_last = 3'd7;
    endcase
  endfunction

  // index of the last schedule word: 4 * (nk + 7) - 1
  function automatic logic [WIDX_W-1:0] words_last(input logic [1:0] mode);
    unique case (mode)
      MODE_128: words_last = 6'd43;
      MODE_192: words_last = 6'd51;
      default:  words_last = 6'd59;
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] rounds_for(input logic [1:0] mode);
    unique case (mode)
      MODE_128: rounds_for = 4'd10;
      MODE_192: rounds_for = 4'd12;
      default:  rounds_for = 4'd14;
    endcase
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [WORD_W-1:0] sbox_word(input logic [WORD_W-1:0] w);
    sbox_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte k of the state sits at [127-8k -: 8]
  function automatic logic [BLOCK_W-1:0] sub_shift(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(c*4 + r) -: 8] = SBOX[s[127 - 8*(((c + r) % 4)*4 + r) -: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [WORD_W-1:0] mix_col(input logic [WORD_W-1:0] w);
    logic [7:0] a0, a1, a2, a3, all;
    a0  = w[31:24];
    a1  = w[23:16];
    a2  = w[15:8];
    a3  = w[7:0];
    all = a0 ^ a1 ^ a2 ^ a3;
    mix_col = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
               a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
  endfunction

  function automatic logic [BLOCK_W-1:0] mix_block(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      t[127 - 32*c -: 32] = mix_col(s[127 - 32*c -: 32]);
    end
    mix_block = t;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/aesenc_key_expand.sv =====
`default_nettype none

module aesenc_key_expand
  import aesenc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [1:0]           key_mode,
  input  wire logic [KEY_W-1:0]     key_0,
  input  wire logic [KEY_W-1:0]     key_1,
  input  wire logic [KEY_W-1:0]     key_2,
  input  wire logic [KEY_W-1:0]     key_3,
  input  wire logic                 rd_en,
  input  wire logic [ROW_W-1:0]     rd_row,
  output logic      [BLOCK_W-1:0]   rd_key,
  output exp_status_t               status
);

  logic              active;
  logic [WIDX_W-1:0] widx;
  logic [2:0]        jcnt;
  logic [7:0]        rcon;
  logic [WORD_W-1:0] win [8];

  logic [WORD_W-1:0] key_word [8];
  logic [WORD_W-1:0] back_word;
  logic [WORD_W-1:0] mod_word;
  logic [WORD_W-1:0] new_word;
  logic              is_key;
  logic              last_word;

  always_comb begin
    key_word[0] = key_0[63:32];
    key_word[1] = key_0[31:0];
    key_word[2] = key_1[63:32];
    key_word[3] = key_1[31:0];
    key_word[4] = key_2[63:32];
    key_word[5] = key_2[31:0];
    key_word[6] = key_3[63:32];
    key_word[7] = key_3[31:0];
  end

  // w[i - nk] tap of the history line
  always_comb begin
    unique case (key_mode)
      MODE_128: back_word = win[3];
      MODE_192: back_word = win[5];
      default:  back_word = win[7];
    endcase
  end

  assign is_key    = (widx <= {3'b000, nk_last(key_mode)});
  assign last_word = (widx == words_last(key_mode));

  always_comb begin
    mod_word = win[0];
    if (jcnt == 3'd0) begin
      mod_word = sbox_word({win[0][23:0], win[0][31:24]}) ^ {rcon, 24'h000000};
    end else if (nk_last(key_mode) == 3'd7 && jcnt == 3'd4) begin
      mod_word = sbox_word(win[0]);
    end
    new_word = is_key ? key_word[widx[2:0]] : (back_word ^ mod_word);
  end

  assign status.busy = active;
  assign status.done = active && last_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      widx   <= '0;
      jcnt   <= '0;
      rcon   <= RCON_FIRST;
    end else if (start) begin
      active <= 1'b1;
      widx   <= '0;
      jcnt   <= '0;
      rcon   <= RCON_FIRST;
    end else if (active) begin
      widx <= widx + 1'b1;
      jcnt <= (jcnt == nk_last(key_mode)) ? 3'd0 : jcnt + 1'b1;
      if (!is_key && jcnt == 3'd0) begin
        rcon <= xtime(rcon);
      end
      if (last_word) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      win[0] <= new_word;
      for (int k = 1; k < 8; k++) begin
        win[k] <= win[k-1];
      end
    end
  end

  // one bank per column of the round key, one row per round
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [WORD_W-1:0] mem [15];
    logic [WORD_W-1:0] rd_word;

    always_ff @(posedge clk) begin
      if (active && widx[1:0] == 2'(b)) begin
        mem[widx[5:2]] <= new_word;
      end
      if (rd_en) begin
        rd_word <= mem[rd_row];
      end
    end
  end

  assign rd_key = {g_bank[0].rd_word, g_bank[1].rd_word,
                   g_bank[2].rd_word, g_bank[3].rd_word};

endmodule

`default_nettype wire

// ===== rtl/core/aes_block_encrypt_core.sv =====
// AES-128/192/256 block encryption, one round per cycle on a shared round unit while the output is not stalled.
// The first block after reset or after a write to the mode or a key register first runs
// key expansion of 4 * (Nk + 7) schedule words (44, 52 or 60). A new block is
// accepted only in idle, after the final round of the previous block has been
// taken into the output register.
// Reset (rst, synchronous): key registers cleared, schedule marked stale, outputs idle.
`default_nettype none

module aes_block_encrypt_core
  import aesenc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [BLOCK_W-1:0]    s_tdata,   // plain_high[63:0], plain_low[127:64]
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [BLOCK_W-1:0]    m_tdata,   // cipher_high[63:0], cipher_low[127:64]
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [KEY_W-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EXPAND = 3'b010,
    S_ROUND  = 3'b100
  } state_t;

  state_t state, state_next;

  logic [1:0]         key_mode;
  logic [KEY_W-1:0]   key_0, key_1, key_2, key_3;
  logic               fresh;
  logic [BLOCK_W-1:0] st;
  logic [ROW_W-1:0]   rnd;
  logic [BLOCK_W-1:0] rk;
  logic [BLOCK_W-1:0] round_out;
  logic [BLOCK_W-1:0] shifted;
  logic               accept;
  logic               last_round;
  logic               stall;
  logic               exp_start;
  logic               rd_en;
  logic [ROW_W-1:0]   rd_row;
  exp_status_t        exp_status;

  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign last_round = (rnd == rounds_for(key_mode));
  assign stall      = (state == S_ROUND) && last_round && m_tvalid && !m_tready;
  assign exp_start  = accept && !fresh;

  always_comb begin
    rd_en  = 1'b0;
    rd_row = '0;
    unique case (state)
      S_IDLE:   rd_en = accept && fresh;
      S_EXPAND: rd_en = exp_status.done;
      S_ROUND: begin
        rd_en  = !last_round;
        rd_row = rnd + 1'b1;
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = fresh ? S_ROUND : S_EXPAND;
      S_EXPAND: if (exp_status.done) state_next = S_ROUND;
      S_ROUND:  if (last_round && !stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // round 0 is the bare key add; the final round skips mix columns
  always_comb begin
    shifted = sub_shift(st);
    if (rnd == '0) begin
      round_out = st ^ rk;
    end else if (last_round) begin
      round_out = shifted ^ rk;
    end else begin
      round_out = mix_block(shifted) ^ rk;
    end
  end

  aesenc_key_expand u_key_expand (
    .clk      (clk),
    .rst      (rst),
    .start    (exp_start),
    .key_mode (key_mode),
    .key_0    (key_0),
    .key_1    (key_1),
    .key_2    (key_2),
    .key_3    (key_3),
    .rd_en    (rd_en),
    .rd_row   (rd_row),
    .rd_key   (rk),
    .status   (exp_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_mode <= MODE_128;
      key_0    <= '0;
      key_1    <= '0;
      key_2    <= '0;
      key_3    <= '0;
      fresh    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_MODE: begin
          key_mode <= cfg_data[1:0];
          fresh    <= 1'b0;
        end
        REG_KEY_0: begin
          key_0 <= cfg_data;
          fresh <= 1'b0;
        end
        REG_KEY_1: begin
          key_1 <= cfg_data;
          fresh <= 1'b0;
        end
        REG_KEY_2: begin
          key_2 <= cfg_data;
          fresh <= 1'b0;
        end
        REG_KEY_3: begin
          key_3 <= cfg_data;
          fresh <= 1'b0;
        end
        default: ;
      endcase
    end else if (state == S_EXPAND && exp_status.done) begin
      fresh <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rnd      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_ROUND && last_round && !stall) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        rnd <= '0;
      end else if (state == S_ROUND && !stall) begin
        rnd <= rnd + 1'b1;
      end
    end
  end

  // tdata carries plain_high in the low half; state byte 0 is its top byte
  always_ff @(posedge clk) begin
    if (accept) begin
      st <= {s_tdata[63:0], s_tdata[127:64]};
    end else if (state == S_ROUND && !stall) begin
      st <= round_out;
      if (last_round) begin
        m_tdata <= {round_out[63:0], round_out[127:64]};
      end
    end
  end

`ifndef SYNTHESIS
  a_exp_only_in_expand: assert property (@(posedge clk) disable iff (rst)
    exp_status.busy |-> state == S_EXPAND)
    else $error("key expansion running outside expand state");

  a_round_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND |-> rnd <= rounds_for(key_mode))
    else $error("round counter past last round");

  a_result_from_round: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_ROUND))
    else $error("result raised outside round state");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && !last_round) |=> state == S_ROUND)
    else $error("round loop left early");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none

module tb;
  import aesenc_pkg::*;

  localparam logic [1:0] MODE_256   = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;  // unused code, behaves as 256-bit
  localparam logic [7:0] AES_POLY   = 8'h1b;
  localparam logic [7:0] AFFINE_C   = 8'h63;
  localparam int         NUM_RANDOM = 1530;

  typedef struct {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } cipher_t;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [BLOCK_W-1:0] s_tdata = '0;    // plain_high[63:0], plain_low[127:64]
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [BLOCK_W-1:0] m_tdata;         // cipher_high[63:0], cipher_low[127:64]
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KEY_W-1:0] cfg_data = '0;

  aes_block_encrypt_core DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state: register copies, round keys, byte substitution table
  logic [1:0]  mode_cfg;
  logic [63:0] key_cfg [4];
  logic [31:0] round_words [60];
  logic [7:0]  sub_lut [256];

  cipher_t pending_cipher_q [$];
  cipher_t want;
  int  fail_count = 0;
  bit  gaps_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? AES_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf_double(a);
    end
    return p;
  endfunction

  // S-box from the field inverse followed by the affine map
  function automatic void build_sub_lut();
    logic [7:0] inv, rot, s;
    for (int x = 0; x < 256; x++) begin
      inv = '0;
      for (int y = 1; y < 256; y++) begin
        if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
      end
      s = inv;
      rot = inv;
      for (int k = 0; k < 4; k++) begin
        rot = {rot[6:0], rot[7]};
        s ^= rot;
      end
      sub_lut[x] = s ^ AFFINE_C;
    end
  endfunction

  function automatic int key_word_count(input logic [1:0] mode);
    case (mode)
      MODE_128: return 4;
      MODE_192: return 6;
      default:  return 8;
    endcase
  endfunction

  function automatic logic [31:0] sub_bytes_word(input logic [31:0] w);
    return {sub_lut[w[31:24]], sub_lut[w[23:16]], sub_lut[w[15:8]], sub_lut[w[7:0]]};
  endfunction

  function automatic void expand_round_keys();
    int nk, total;
    logic [31:0] t;
    logic [7:0] rc;
    nk = key_word_count(mode_cfg);
    total = 4 * (nk + 7);
    rc = 8'h01;
    for (int i = 0; i < nk; i++) begin
      round_words[i] = i[0] ? key_cfg[i >> 1][31:0] : key_cfg[i >> 1][63:32];
    end
    for (int i = nk; i < total; i++) begin
      t = round_words[i - 1];
      if (i % nk == 0) begin
        t = sub_bytes_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_double(rc);
      end else if (nk == 8 && i % nk == 4) begin
        t = sub_bytes_word(t);
      end
      round_words[i] = round_words[i - nk] ^ t;
    end
  endfunction

  // byte k of the block sits at [127-8k -: 8]
  function automatic logic [127:0] aes_encrypt(input logic [127:0] plain);
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [31:0] w;
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] res;
    int nr;
    nr = key_word_count(mode_cfg) + 6;
    for (int k = 0; k < 16; k++) st[k] = plain[127 - 8*k -: 8];
    for (int r = 0; r <= nr; r++) begin
      if (r > 0) begin
        for (int c = 0; c < 4; c++) begin
          for (int j = 0; j < 4; j++) tmp[c*4 + j] = sub_lut[st[((c + j) % 4)*4 + j]];
        end
        st = tmp;
        if (r < nr) begin
          for (int c = 0; c < 4; c++) begin
            a0 = st[c*4]; a1 = st[c*4 + 1]; a2 = st[c*4 + 2]; a3 = st[c*4 + 3];
            all = a0 ^ a1 ^ a2 ^ a3;
            st[c*4]     = a0 ^ all ^ gf_double(a0 ^ a1);
            st[c*4 + 1] = a1 ^ all ^ gf_double(a1 ^ a2);
            st[c*4 + 2] = a2 ^ all ^ gf_double(a2 ^ a3);
            st[c*4 + 3] = a3 ^ all ^ gf_double(a3 ^ a0);
          end
        end
      end
      for (int c = 0; c < 4; c++) begin
        w = round_words[r*4 + c];
        for (int j = 0; j < 4; j++) st[c*4 + j] ^= w[31 - 8*j -: 8];
      end
    end
    for (int k = 0; k < 16; k++) res[127 - 8*k -: 8] = st[k];
    return res;
  endfunction

  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // all driving tasks start and end just after a rising edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_KEY_MODE: mode_cfg = data[1:0];
      REG_KEY_0:    key_cfg[0] = data;
      REG_KEY_1:    key_cfg[1] = data;
      REG_KEY_2:    key_cfg[2] = data;
      REG_KEY_3:    key_cfg[3] = data;
      default: ;    // out of range, ignored
    endcase
    @(posedge clk);
  endtask

  task automatic write_key(input logic [63:0] k0, k1, k2, k3);
    write_reg(REG_KEY_0, k0);
    write_reg(REG_KEY_1, k1);
    write_reg(REG_KEY_2, k2);
    write_reg(REG_KEY_3, k3);
  endtask

  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    logic [127:0] c;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {lo, hi};
    do @(posedge clk); while (s_tready !== 1'b1);
    expand_round_keys();
    c = aes_encrypt({hi, lo});
    pending_cipher_q.push_back('{cipher_high: c[127:64], cipher_low: c[63:0]});
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_cipher_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  // output stall bursts
  always begin
    @(posedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    m_tready <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (pending_cipher_q.size() == 0) begin
        $error("unexpected ciphertext %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_cipher_q.pop_front();
        if (m_tdata[63:0] !== want.cipher_high) begin
          $error("cipher_high mismatch: expected %h, got %h", want.cipher_high, m_tdata[63:0]);
          fail_count++;
        end
        if (m_tdata[127:64] !== want.cipher_low) begin
          $error("cipher_low mismatch: expected %h, got %h", want.cipher_low, m_tdata[127:64]);
          fail_count++;
        end
      end
    end
  end

  task automatic test_reset_key();
    send_block('0, '0);
    send_block('1, '1);
    wait_drained();
  endtask

  // standard key 00..1f in all lengths, including the spare mode code
  task automatic test_key_lengths();
    logic [1:0] modes [4];
    modes = '{MODE_128, MODE_192, MODE_256, MODE_SPARE};
    write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
              64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    foreach (modes[m]) begin
      write_reg(REG_KEY_MODE, {{62{1'b1}}, modes[m]});
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
      wait_drained();
    end
    // key bytes beyond the key length must not matter
    write_reg(REG_KEY_MODE, {62'h0, MODE_128});
    write_reg(REG_KEY_2, pick64());
    write_reg(REG_KEY_3, pick64());
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    wait_drained();
    write_reg(REG_KEY_MODE, {62'h0, MODE_192});
    write_reg(REG_KEY_3, pick64());
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    wait_drained();
  endtask

  task automatic test_extremes();
    write_key('1, '1, '1, '1);
    write_reg(REG_KEY_MODE, {62'h0, MODE_128});
    send_block('1, '1);
    send_block('0, '0);
    wait_drained();
    write_reg(REG_KEY_MODE, {62'h0, MODE_256});
    send_block('1, '0);
    send_block('0, '1);
    wait_drained();
  endtask

  task automatic test_bad_index();
    for (int k = 1; k <= 3; k++) write_reg(CFG_IDX_W'(int'(REG_KEY_3) + k), pick64());
    send_block(pick64(), pick64());
    wait_drained();
    write_reg(REG_KEY_0, pick64());
    write_reg(CFG_IDX_W'(int'(REG_KEY_3) + 1), pick64());
    send_block(pick64(), pick64());
    wait_drained();
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    write_reg(REG_KEY_MODE, {62'h0, MODE_192});
    write_key(pick64(), pick64(), pick64(), pick64());
    repeat (4) send_block(pick64(), pick64());
    wait_drained();
    gaps_on = 1'b1;
  endtask

  // sender holds off until the pipe is empty before every request
  task automatic test_drained_sends();
    repeat (4) begin
      wait_drained();
      send_block(pick64(), pick64());
    end
    wait_drained();
  endtask

  task automatic random_reconfig();
    if ($urandom_range(0, 3) != 0)
      write_reg(REG_KEY_MODE, {$urandom, $urandom} & ~64'h3 | 64'($urandom_range(0, 3)));
    for (int r = 0; r < 4; r++) begin
      if ($urandom_range(0, 3) != 0) write_reg(CFG_IDX_W'(int'(REG_KEY_0) + r), pick64());
    end
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'(int'(REG_KEY_3) + $urandom_range(1, 3)), pick64());
  endtask

  task automatic test_random_traffic();
    int sent, burst;
    sent = 0;
    while (sent < NUM_RANDOM) begin
      random_reconfig();
      burst = $urandom_range(20, 80);
      gaps_on = (sent < NUM_RANDOM - 200) ? ($urandom_range(0, 3) != 0) : 1'b0;
      for (int j = 0; j < burst && sent < NUM_RANDOM; j++) begin
        send_block(pick64(), pick64());
        sent++;
      end
      wait_drained();
    end
  endtask

  initial begin
    build_sub_lut();
    mode_cfg = MODE_128;
    foreach (key_cfg[r]) key_cfg[r] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_key();
    test_key_lengths();
    test_extremes();
    test_bad_index();
    test_back_to_back();
    test_drained_sends();
    test_random_traffic();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/aesenc_pkg.sv
rtl/core/aesenc_key_expand.sv
rtl/core/aes_block_encrypt_core.sv
verif/tb.sv
